/* design/ilir_pkg.sv */
`default_nettype none
package ilir_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 7;
  localparam int TOTAL_W = 7;

  localparam logic signed [VALUE_W-1:0] ERR_VALUE  = -32'sd1;
  localparam logic signed [VALUE_W-1:0] ZERO_VALUE = 32'sd0;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_RESP
  } state_t;

  // Operation broadcast to every cell of the row.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_LOAD,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     at;
    logic     above;
  } cell_ctl_t;

endpackage
`default_nettype wire

/* design/ilir_in_if.sv */
`default_nettype none
interface ilir_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           command;
  logic [ilir_pkg::POS_W-1:0]           position;
  logic signed [ilir_pkg::VALUE_W-1:0]  item_value;

  modport source (output valid, output command, output position, output item_value,
                  input ready);
  modport sink (input valid, input command, input position, input item_value,
                output ready);
endinterface
`default_nettype wire

/* design/ilir_out_if.sv */
`default_nettype none
interface ilir_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ilir_pkg::VALUE_W-1:0]  result_value;
  logic [1:0]                           status;
  logic [ilir_pkg::TOTAL_W-1:0]         entry_total;

  modport source (output valid, output result_value, output status, output entry_total,
                  input ready);
  modport sink (input valid, input result_value, input status, input entry_total,
                output ready);
endinterface
`default_nettype wire

/* design/ilir_cell.sv */
`default_nettype none
// One list slot plus one stage of the read chain that walks values toward cell 0.
module ilir_cell (
  input  wire                                 clk,
  input  wire ilir_pkg::cell_ctl_t            ctl,
  input  wire signed [ilir_pkg::VALUE_W-1:0]  ins_value,
  input  wire signed [ilir_pkg::VALUE_W-1:0]  left_entry,
  input  wire signed [ilir_pkg::VALUE_W-1:0]  right_entry,
  input  wire signed [ilir_pkg::VALUE_W-1:0]  right_bus,
  output logic signed [ilir_pkg::VALUE_W-1:0] entry_o,
  output logic signed [ilir_pkg::VALUE_W-1:0] bus_o
);

  logic signed [ilir_pkg::VALUE_W-1:0] entry_r, entry_nxt;
  logic signed [ilir_pkg::VALUE_W-1:0] bus_r, bus_nxt;

  always_comb begin
    entry_nxt = entry_r;
    bus_nxt   = bus_r;
    case (ctl.op)
      ilir_pkg::CELL_INSERT: begin
        if (ctl.at) begin
          entry_nxt = ins_value;
        end else if (ctl.above) begin
          entry_nxt = left_entry;
        end
      end
      ilir_pkg::CELL_REMOVE: begin
        if (ctl.at || ctl.above) begin
          entry_nxt = right_entry;
        end
      end
      ilir_pkg::CELL_LOAD:  bus_nxt = entry_r;
      ilir_pkg::CELL_SHIFT: bus_nxt = right_bus;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    bus_r   <= bus_nxt;
  end

  assign entry_o = entry_r;
  assign bus_o   = bus_r;

endmodule
`default_nettype wire

/* design/indexed_list_insert_remove.sv */
// Insert, append and any rejected command pass through the result register into the
// output register. Remove and read at position p first load every entry into the read
// chain, which then moves one cell toward cell 0 per cycle until the target reaches cell 0.
// One command at a time: the next beat is taken only once the result has moved to the
// output register, which waits while an earlier result is unaccepted. Reset (synchronous,
// rst_n low) empties the list and drops any pending result beat; cell contents are not cleared.
`default_nettype none
module indexed_list_insert_remove #(
  parameter int CAPACITY = 64
) (
  input wire         clk,
  input wire         rst_n,
  ilir_in_if.sink    in_bus,
  ilir_out_if.source out_bus
);

  // Count must hold CAPACITY itself; cell indexes only need CAPACITY-1.
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMPW = ((CW > ilir_pkg::POS_W) ? CW : ilir_pkg::POS_W) + 1;

  ilir_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [IW-1:0]    tgt_r, tgt_nxt;
  logic [IW-1:0]    cnt_r, cnt_nxt;
  logic             rm_r, rm_nxt;

  logic signed [ilir_pkg::VALUE_W-1:0] res_value_r, res_value_nxt;
  ilir_pkg::status_t                   res_status_r, res_status_nxt;

  logic                                out_valid_r, out_valid_nxt;
  logic signed [ilir_pkg::VALUE_W-1:0] out_value_r, out_value_nxt;
  ilir_pkg::status_t                   out_status_r, out_status_nxt;
  logic [ilir_pkg::TOTAL_W-1:0]        out_total_r, out_total_nxt;

  // Row of cells and the shared control they all see.
  ilir_pkg::cell_op_t cell_op;
  logic [IW-1:0]      tgt_sel;
  ilir_pkg::cell_ctl_t                 ctl_w   [CAPACITY];
  logic signed [ilir_pkg::VALUE_W-1:0] entry_w [CAPACITY];
  logic signed [ilir_pkg::VALUE_W-1:0] bus_w   [CAPACITY];

  ilir_pkg::cmd_t  cmd;
  logic [CMPW-1:0] pos_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [IW-1:0]   pos_idx;
  logic            full;
  logic            ins_pos_ok;
  logic            rd_pos_ok;
  logic            slot_free;

  assign cmd        = ilir_pkg::cmd_t'(in_bus.command);
  assign pos_ext    = CMPW'(in_bus.position);
  assign cnt_ext    = CMPW'(count_r);
  assign pos_idx    = IW'(pos_ext - CMPW'(1));
  assign full       = (count_r == CW'(CAPACITY));
  assign ins_pos_ok = (pos_ext != '0) && (pos_ext <= cnt_ext + CMPW'(1));
  assign rd_pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign slot_free  = !out_valid_r || out_bus.ready;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    tgt_nxt        = tgt_r;
    cnt_nxt        = cnt_r;
    rm_nxt         = rm_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_total_nxt  = out_total_r;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    cell_op        = ilir_pkg::CELL_HOLD;
    tgt_sel        = tgt_r;
    in_bus.ready   = 1'b0;

    case (state_r)
      ilir_pkg::S_IDLE: begin
        in_bus.ready = 1'b1;
        if (in_bus.valid) begin
          case (cmd)
            ilir_pkg::CMD_INSERT, ilir_pkg::CMD_APPEND: begin
              state_nxt = ilir_pkg::S_RESP;
              // Position is checked before fullness; append is always in range.
              if ((cmd == ilir_pkg::CMD_INSERT) && !ins_pos_ok) begin
                res_value_nxt  = ilir_pkg::ERR_VALUE;
                res_status_nxt = ilir_pkg::ST_RANGE;
              end else if (full) begin
                res_value_nxt  = ilir_pkg::ERR_VALUE;
                res_status_nxt = ilir_pkg::ST_FULL;
              end else begin
                cell_op        = ilir_pkg::CELL_INSERT;
                tgt_sel        = (cmd == ilir_pkg::CMD_APPEND) ? IW'(count_r) : pos_idx;
                count_nxt      = count_r + CW'(1);
                res_value_nxt  = ilir_pkg::ZERO_VALUE;
                res_status_nxt = ilir_pkg::ST_OK;
              end
            end
            ilir_pkg::CMD_REMOVE, ilir_pkg::CMD_READ: begin
              if (!rd_pos_ok) begin
                state_nxt      = ilir_pkg::S_RESP;
                res_value_nxt  = ilir_pkg::ERR_VALUE;
                res_status_nxt = ilir_pkg::ST_RANGE;
              end else begin
                // Snapshot every entry into the read chain, then walk it down.
                state_nxt = ilir_pkg::S_WALK;
                cell_op   = ilir_pkg::CELL_LOAD;
                tgt_nxt   = pos_idx;
                cnt_nxt   = pos_idx;
                rm_nxt    = (cmd == ilir_pkg::CMD_REMOVE);
              end
            end
            default: ;
          endcase
        end
      end
      ilir_pkg::S_WALK: begin
        if (cnt_r == '0) begin
          // The target value now sits in cell 0 of the read chain.
          res_value_nxt  = bus_w[0];
          res_status_nxt = ilir_pkg::ST_OK;
          state_nxt      = ilir_pkg::S_RESP;
          if (rm_r) begin
            cell_op   = ilir_pkg::CELL_REMOVE;
            count_nxt = count_r - CW'(1);
          end
        end else begin
          cell_op = ilir_pkg::CELL_SHIFT;
          cnt_nxt = cnt_r - IW'(1);
        end
      end
      ilir_pkg::S_RESP: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = res_value_r;
          out_status_nxt = res_status_r;
          out_total_nxt  = ilir_pkg::TOTAL_W'(count_r);
          state_nxt      = ilir_pkg::S_IDLE;
        end
      end
      default: state_nxt = ilir_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ilir_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r        <= tgt_nxt;
    cnt_r        <= cnt_nxt;
    rm_r         <= rm_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_total_r  <= out_total_nxt;
  end

  // Each cell learns whether it is the target slot or lies above it; the
  // neighbors at the two ends of the row see zero.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ilir_pkg::VALUE_W-1:0] left_w;
    logic signed [ilir_pkg::VALUE_W-1:0] right_w;
    logic signed [ilir_pkg::VALUE_W-1:0] rbus_w;

    if (i == 0) begin : g_first
      assign left_w = ilir_pkg::ZERO_VALUE;
    end else begin : g_mid_l
      assign left_w = entry_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = ilir_pkg::ZERO_VALUE;
      assign rbus_w  = ilir_pkg::ZERO_VALUE;
    end else begin : g_mid_r
      assign right_w = entry_w[i+1];
      assign rbus_w  = bus_w[i+1];
    end

    assign ctl_w[i] = '{op: cell_op, at: (tgt_sel == IW'(i)), above: (tgt_sel < IW'(i))};

    ilir_cell u_cell (
      .clk         (clk),
      .ctl         (ctl_w[i]),
      .ins_value   (in_bus.item_value),
      .left_entry  (left_w),
      .right_entry (right_w),
      .right_bus   (rbus_w),
      .entry_o     (entry_w[i]),
      .bus_o       (bus_w[i])
    );
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.result_value = out_value_r;
  assign out_bus.status       = out_status_r;
  assign out_bus.entry_total  = out_total_r;

endmodule
`default_nettype wire
